// ----- design/rsc_pkg.sv -----
package rsc_pkg;

    // Size of the destination digit store.
    localparam int NDIGITS = 32;
    localparam int IDX_W   = $clog2(NDIGITS);
    localparam int CNT_W   = $clog2(NDIGITS + 1);

    // Field and register widths.
    localparam int CHAR_W = 8;
    localparam int OUT_W  = 7;
    localparam int BASE_W = 6;
    localparam int VAL_W  = 6;

    // Datapath widths. A stored digit is at most 35 and a base at most 36, so the
    // running sum digit*base+carry stays at or below 2520 and the carry at or below 1260.
    localparam int T_W         = 12;
    localparam int C_W         = 11;
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 18;
    localparam int P_W         = T_W + RECIP_W;

    // Queue between the front and the back.
    localparam int Q_DEPTH = 4;
    localparam int QA_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);

    // Base limits and reset value.
    localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
    localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
    localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;
    localparam logic [RECIP_W-1:0] RECIP_RESET = 18'd26214;

    // ASCII codes.
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] ASCII_LOW_A = 8'h61;
    localparam logic [CHAR_W-1:0] ASCII_LOW_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] ASCII_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] ASCII_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'd10;

    // Configuration register indexes.
    localparam logic [0:0] REG_SOURCE_BASE = 1'b0;
    localparam logic [0:0] REG_TARGET_BASE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_MUL,
        ST_DIV,
        ST_ERD,
        ST_EMIT,
        ST_ZERO
    } back_state_t;

    // One classified character.
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
    } q_item_t;

    // Head of the queue as the back sees it.
    typedef struct packed {
        logic    valid;
        q_item_t item;
    } rsc_q_t;

    // Active bases, already clamped, and the reciprocal of the target base.
    typedef struct packed {
        logic [BASE_W-1:0]  sb;
        logic [BASE_W-1:0]  tb;
        logic [RECIP_W-1:0] recip;
    } rsc_cfg_t;

    typedef struct packed {
        logic busy;
    } rsc_stat_t;

    function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
        logic [BASE_W-1:0] r;
        r = b;
        if (b < BASE_MIN) r = BASE_MIN;
        else if (b > BASE_MAX) r = BASE_MAX;
        return r;
    endfunction

    function automatic logic [VAL_W-1:0] char_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = '0;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) v = c - ASCII_ZERO;
        else if (c >= ASCII_LOW_A && c <= ASCII_LOW_Z) v = c - ASCII_LOW_A + LETTER_BASE;
        else if (c >= ASCII_UP_A && c <= ASCII_UP_Z) v = c - ASCII_UP_A + LETTER_BASE;
        return v[VAL_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] value_char(input logic [VAL_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < VAL_W'(10)) c = ASCII_ZERO + CHAR_W'(d);
        else c = ASCII_LOW_A + CHAR_W'(d) - LETTER_BASE;
        return c[OUT_W-1:0];
    endfunction

    // floor(2^18 / b) for every legal base.
    function automatic logic [RECIP_W-1:0] recip_of(input logic [BASE_W-1:0] b);
        logic [RECIP_W-1:0] r;
        unique case (b)
            6'd2:    r = 18'd131072;
            6'd3:    r = 18'd87381;
            6'd4:    r = 18'd65536;
            6'd5:    r = 18'd52428;
            6'd6:    r = 18'd43690;
            6'd7:    r = 18'd37449;
            6'd8:    r = 18'd32768;
            6'd9:    r = 18'd29127;
            6'd10:   r = 18'd26214;
            6'd11:   r = 18'd23831;
            6'd12:   r = 18'd21845;
            6'd13:   r = 18'd20164;
            6'd14:   r = 18'd18724;
            6'd15:   r = 18'd17476;
            6'd16:   r = 18'd16384;
            6'd17:   r = 18'd15420;
            6'd18:   r = 18'd14563;
            6'd19:   r = 18'd13797;
            6'd20:   r = 18'd13107;
            6'd21:   r = 18'd12483;
            6'd22:   r = 18'd11915;
            6'd23:   r = 18'd11397;
            6'd24:   r = 18'd10922;
            6'd25:   r = 18'd10485;
            6'd26:   r = 18'd10082;
            6'd27:   r = 18'd9709;
            6'd28:   r = 18'd9362;
            6'd29:   r = 18'd9039;
            6'd30:   r = 18'd8738;
            6'd31:   r = 18'd8456;
            6'd32:   r = 18'd8192;
            6'd33:   r = 18'd7943;
            6'd34:   r = 18'd7710;
            6'd35:   r = 18'd7489;
            6'd36:   r = 18'd7281;
            default: r = 18'd131072;
        endcase
        return r;
    endfunction

endpackage

// ----- design/rsc_ram.sv -----
module rsc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/rsc_front.sv -----
module rsc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [rsc_pkg::CHAR_W-1:0]   digit_char,
    input  logic                         final_digit,
    output rsc_pkg::rsc_q_t              q_head,
    input  logic                         q_pop
);

    rsc_pkg::q_item_t             entry_reg [rsc_pkg::Q_DEPTH];
    logic [rsc_pkg::QA_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rsc_pkg::QA_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rsc_pkg::QC_W-1:0]     count_reg, count_next;
    logic                         push;
    rsc_pkg::q_item_t             item;

    // Classify the character as it arrives.
    assign item.value = rsc_pkg::char_value(digit_char);
    assign item.last  = final_digit;

    assign in_stall = (count_reg == rsc_pkg::QC_W'(rsc_pkg::Q_DEPTH));
    assign push     = in_valid && !in_stall;

    assign q_head.valid = (count_reg != '0);
    assign q_head.item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = q_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + rsc_pkg::QC_W'(push) - rsc_pkg::QC_W'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

// ----- design/rsc_back.sv -----
module rsc_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rsc_pkg::rsc_q_t             q_head,
    output logic                        q_pop,
    input  rsc_pkg::rsc_cfg_t           cfg,
    output rsc_pkg::rsc_stat_t          stat,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [rsc_pkg::OUT_W-1:0]   out_char,
    output logic                        out_last,
    output logic                        overflow
);

    rsc_pkg::back_state_t           state_reg, state_next;
    logic [rsc_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic [rsc_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [rsc_pkg::CNT_W-1:0]      newcnt_reg, newcnt_next;
    logic [rsc_pkg::C_W-1:0]        carry_reg, carry_next;
    logic [rsc_pkg::T_W-1:0]        t_reg, t_next;
    logic [rsc_pkg::P_W-1:0]        p_reg, p_next;
    logic                           last_reg, last_next;
    logic                           ovf_reg, ovf_next;
    logic                           out_valid_reg, out_valid_next;
    logic [rsc_pkg::OUT_W-1:0]      out_char_reg, out_char_next;
    logic                           out_last_reg, out_last_next;
    logic                           out_ovf_reg, out_ovf_next;

    logic                           ram_we;
    logic [rsc_pkg::IDX_W-1:0]      ram_waddr;
    logic [rsc_pkg::VAL_W-1:0]      ram_wdata;
    logic                           ram_re;
    logic [rsc_pkg::IDX_W-1:0]      ram_raddr;
    logic [rsc_pkg::VAL_W-1:0]      ram_rdata;

    logic                           out_free;
    logic                           pass_done;
    logic [rsc_pkg::VAL_W-1:0]      cur_digit;
    logic [rsc_pkg::C_W-1:0]        q_est;
    logic [rsc_pkg::T_W-1:0]        rem_raw;
    logic [rsc_pkg::T_W-1:0]        rem_fix;
    logic [rsc_pkg::C_W-1:0]        quot;
    logic [rsc_pkg::CNT_W-1:0]      idx_inc;

    rsc_ram #(
        .WIDTH (rsc_pkg::VAL_W),
        .DEPTH (rsc_pkg::NDIGITS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;
    assign overflow  = out_ovf_reg;
    assign stat.busy = (state_reg != rsc_pkg::ST_IDLE);

    // Entries at or above the fill count hold stale data and read as zero.
    assign cur_digit = (idx_reg < cnt_reg) ? ram_rdata : '0;
    assign pass_done = (idx_reg == rsc_pkg::CNT_W'(rsc_pkg::NDIGITS))
                    || ((idx_reg >= cnt_reg) && (carry_reg == '0));
    assign idx_inc   = idx_reg + 1'b1;

    // Reciprocal division: the estimate is the true quotient or one below it.
    assign q_est   = rsc_pkg::C_W'(p_reg >> rsc_pkg::RECIP_SHIFT);
    assign rem_raw = t_reg - rsc_pkg::T_W'(rsc_pkg::T_W'(q_est) * rsc_pkg::T_W'(cfg.tb));

    always_comb
    begin
        if (rem_raw >= rsc_pkg::T_W'(cfg.tb))
        begin
            rem_fix = rem_raw - rsc_pkg::T_W'(cfg.tb);
            quot    = q_est + 1'b1;
        end
        else
        begin
            rem_fix = rem_raw;
            quot    = q_est;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        newcnt_next    = newcnt_reg;
        carry_next     = carry_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        out_valid_next = out_valid_reg && out_stall;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[rsc_pkg::IDX_W-1:0];
        ram_wdata      = rem_fix[rsc_pkg::VAL_W-1:0];
        ram_re         = 1'b0;
        ram_raddr      = idx_reg[rsc_pkg::IDX_W-1:0];

        unique case (state_reg)
            rsc_pkg::ST_IDLE:
            begin
                if (q_head.valid)
                begin
                    q_pop       = 1'b1;
                    carry_next  = rsc_pkg::C_W'(q_head.item.value);
                    last_next   = q_head.item.last;
                    idx_next    = '0;
                    newcnt_next = '0;
                    ram_re      = 1'b1;
                    ram_raddr   = '0;
                    state_next  = rsc_pkg::ST_MAC;
                end
            end
            rsc_pkg::ST_MAC:
            begin
                if (pass_done)
                begin
                    if (carry_reg != '0)
                    begin
                        ovf_next = 1'b1;
                    end
                    cnt_next = newcnt_reg;
                    if (!last_reg)
                    begin
                        state_next = rsc_pkg::ST_IDLE;
                    end
                    else if (newcnt_reg == '0)
                    begin
                        state_next = rsc_pkg::ST_ZERO;
                    end
                    else
                    begin
                        idx_next   = newcnt_reg - 1'b1;
                        state_next = rsc_pkg::ST_ERD;
                    end
                end
                else
                begin
                    t_next = rsc_pkg::T_W'(cur_digit) * rsc_pkg::T_W'(cfg.sb)
                           + rsc_pkg::T_W'(carry_reg);
                    state_next = rsc_pkg::ST_MUL;
                end
            end
            rsc_pkg::ST_MUL:
            begin
                p_next     = rsc_pkg::P_W'(t_reg) * rsc_pkg::P_W'(cfg.recip);
                state_next = rsc_pkg::ST_DIV;
            end
            rsc_pkg::ST_DIV:
            begin
                ram_we     = 1'b1;
                carry_next = quot;
                if (rem_fix != '0)
                begin
                    newcnt_next = idx_inc;
                end
                idx_next   = idx_inc;
                ram_re     = 1'b1;
                ram_raddr  = idx_inc[rsc_pkg::IDX_W-1:0];
                state_next = rsc_pkg::ST_MAC;
            end
            rsc_pkg::ST_ERD:
            begin
                ram_re     = 1'b1;
                state_next = rsc_pkg::ST_EMIT;
            end
            rsc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rsc_pkg::value_char(ram_rdata);
                    out_last_next  = (idx_reg == '0);
                    out_ovf_next   = ovf_reg;
                    if (idx_reg == '0)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        state_next = rsc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg - 1'b1;
                        state_next = rsc_pkg::ST_ERD;
                    end
                end
            end
            rsc_pkg::ST_ZERO:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = rsc_pkg::ASCII_ZERO[rsc_pkg::OUT_W-1:0];
                    out_last_next  = 1'b1;
                    out_ovf_next   = ovf_reg;
                    cnt_next       = '0;
                    ovf_next       = 1'b0;
                    state_next     = rsc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsc_pkg::ST_IDLE;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        newcnt_reg   <= newcnt_next;
        carry_reg    <= carry_next;
        t_reg        <= t_next;
        p_reg        <= p_next;
        last_reg     <= last_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

endmodule

// ----- design/radix_string_converter.sv -----
// A character enters the queue register; the back pops it once idle and runs its MAC, MUL
// and DIV states for each stored digit it updates (at most NDIGITS), then closes the pass.
// The back takes the next character only after the pass is closed. The pass visits the
// digits in use and any new ones the carry reaches, through the serial multiply,
// reciprocal multiply and remainder steps of the back.
// A final character then emits one beat per digit, each after a store read and an output load.
// Reset clears the queue, the fill count and the overflow flag; both bases return to 10.
module radix_string_converter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_write,
    input  logic [0:0]                   cfg_index,
    input  logic [rsc_pkg::BASE_W-1:0]   cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [rsc_pkg::CHAR_W-1:0]   digit_char,
    input  logic                         final_digit,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rsc_pkg::OUT_W-1:0]    out_char,
    output logic                         out_last,
    output logic                         overflow
);

    // The bases are stored already clamped to the legal range, and the reciprocal of
    // the target base is looked up at write time so the back only multiplies.
    logic [rsc_pkg::BASE_W-1:0]  sb_reg, sb_next;
    logic [rsc_pkg::BASE_W-1:0]  tb_reg, tb_next;
    logic [rsc_pkg::RECIP_W-1:0] recip_reg, recip_next;

    rsc_pkg::rsc_q_t    q_head;
    logic               q_pop;
    rsc_pkg::rsc_cfg_t  cfg;
    rsc_pkg::rsc_stat_t stat;

    always_comb
    begin
        sb_next    = sb_reg;
        tb_next    = tb_reg;
        recip_next = recip_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                rsc_pkg::REG_SOURCE_BASE:
                begin
                    sb_next = rsc_pkg::clamp_base(cfg_data);
                end
                rsc_pkg::REG_TARGET_BASE:
                begin
                    tb_next    = rsc_pkg::clamp_base(cfg_data);
                    recip_next = rsc_pkg::recip_of(rsc_pkg::clamp_base(cfg_data));
                end
                default:
                begin
                    sb_next = sb_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sb_reg    <= rsc_pkg::BASE_RESET;
            tb_reg    <= rsc_pkg::BASE_RESET;
            recip_reg <= rsc_pkg::RECIP_RESET;
        end
        else
        begin
            sb_reg    <= sb_next;
            tb_reg    <= tb_next;
            recip_reg <= recip_next;
        end
    end

    assign cfg.sb    = sb_reg;
    assign cfg.tb    = tb_reg;
    assign cfg.recip = recip_reg;

    // The front decodes each character to its digit value and parks it in a short queue,
    // so the input side takes beats until the queue is full while the back works through the store.
    rsc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .digit_char  (digit_char),
        .final_digit (final_digit),
        .q_head      (q_head),
        .q_pop       (q_pop)
    );

    // The back runs the multiply-add pass over the digit store and, on a final character,
    // streams the digits out most significant first through its output register.
    rsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .cfg       (cfg),
        .stat      (stat),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_char  (out_char),
        .out_last  (out_last),
        .overflow  (overflow)
    );

    // The back only takes an entry that the queue actually holds.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_head.valid)
        else $error("back popped an empty queue");

    // A pop with no push in the same cycle always frees a queue slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !(in_valid && !in_stall)) |=> !in_stall)
        else $error("queue still full after a pop");

    // Taking an entry always starts a pass in the back.
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |=> stat.busy)
        else $error("back idle after taking an entry");

endmodule
